@@ hdl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the pixel curves gradient map.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that cons holds in the same cycle whenever ante holds.
`define PCGM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pcgm assertion failed");

// Checks that cons holds in the cycle after ante holds.
`define PCGM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pcgm assertion failed");

`else

`define PCGM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PCGM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/pcgm_pkg.sv @@
// Package with the codes, constants and types of the pixel curves gradient map.
`default_nettype none

package pcgm_pkg;

    // Item commands.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Table selects of a table write.
    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;
    localparam logic [1:0] SEL_GRAD  = 2'd3;

    // Filter modes; the unused code behaves as bypass.
    localparam logic [1:0] MODE_BYPASS   = 2'd0;
    localparam logic [1:0] MODE_CURVES   = 2'd1;
    localparam logic [1:0] MODE_GRADIENT = 2'd2;

    // BT.601 luma weights, scaled by 1000.
    localparam int unsigned LUMA_R_WEIGHT = 299;
    localparam int unsigned LUMA_G_WEIGHT = 587;
    localparam int unsigned LUMA_B_WEIGHT = 114;

    // Division by 1000 as a multiply by ceil(2^28/1000) and a shift by 28.
    // Exact for every weighted sum up to 255000.
    localparam int unsigned LUMA_RECIP = 268436;
    localparam int unsigned LUMA_SHIFT = 28;

    // One item as it travels down the pipeline.
    typedef struct packed {
        logic        cmd;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [1:0]  sel;
        logic [7:0]  idx;
        logic [31:0] data;
    } t_pix;

    // Write request into one of the lookup tables.
    typedef struct packed {
        logic        we;
        logic [1:0]  sel;
        logic [7:0]  idx;
        logic [31:0] data;
    } t_tbl_wr;

endpackage

`default_nettype wire

@@ hdl/pixel_curves_gradient_map.sv @@
// Top level of the pixel curves gradient map stream.
`default_nettype none
`include "assert_macros.svh"

// The block maps a stream of pixels at one item per clock while the output is not
// stalled. An item is either a table write or a pixel. A table write loads one entry
// of the red, green or blue curve, or one 32-bit gradient entry (alpha, red, green,
// blue bytes), and gives no result. A pixel gives one result pixel. In curves mode
// each channel goes through its own curve; in gradient mode the BT.601 luma
// (299R+587G+114B)/1000 selects a gradient entry whose color replaces the pixel,
// and alpha is scaled by the entry alpha over 255. Pixels with zero alpha, and all
// pixels in bypass mode, pass unchanged. The throughput of one item per clock, while
// the output is not stalled, comes from a six-stage pipeline: input capture with the
// curve reads and luma products, luma sum, reciprocal division, gradient read, alpha
// product, and the output register. The whole pipeline moves when the output
// register is empty or being taken, so a stall loses nothing.
// Tables are written at the same pipeline stage where they are read, which keeps
// writes and pixels in stream order. Tables hold nothing until written, and the
// filter mode may be written only while no items are in flight.

module pixel_curves_gradient_map
    import pcgm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [7:0]  i_pixel_red,
    input  logic [7:0]  i_pixel_green,
    input  logic [7:0]  i_pixel_blue,
    input  logic [7:0]  i_pixel_alpha,
    input  logic [1:0]  i_table_select,
    input  logic [7:0]  i_table_index,
    input  logic [31:0] i_table_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_alpha,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data
);

    // Pipeline advance: the output register is free or is taken this cycle.
    logic        en;
    logic        acc;
    t_pix        in_pix;

    logic [1:0]  r_mode;
    logic [5:1]  r_vld;
    t_pix        r_pix [5:1];
    logic [23:0] r_crv [5:2];

    t_tbl_wr     crv_wr;
    t_tbl_wr     grad_wr;
    logic [7:0]  crv_red;
    logic [7:0]  crv_green;
    logic [7:0]  crv_blue;
    logic [7:0]  luma;
    logic [31:0] grad_entry;

    logic [23:0] r_grad5;
    logic [15:0] r_amul5;

    logic        r_out_vld;
    logic [7:0]  r_out_red;
    logic [7:0]  r_out_green;
    logic [7:0]  r_out_blue;
    logic [7:0]  r_out_alpha;
    logic [7:0]  n_out_red;
    logic [7:0]  n_out_green;
    logic [7:0]  n_out_blue;
    logic [7:0]  n_out_alpha;
    logic [16:0] div_t;
    logic [16:0] div_s;

    assign en      = !r_out_vld || !i_stall;
    assign acc     = i_valid && en;
    assign o_stall = !en;

    assign in_pix = '{cmd: i_command, red: i_pixel_red, green: i_pixel_green,
                      blue: i_pixel_blue, alpha: i_pixel_alpha, sel: i_table_select,
                      idx: i_table_index, data: i_table_data};

    // The mode register accepts a write in every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BYPASS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    // Valid bits travel alongside the payload and clear on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[4:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pix[1] <= in_pix;
            for (int k = 2; k <= 5; k++) begin
                r_pix[k] <= r_pix[k - 1];
            end
            r_crv[2] <= {crv_red, crv_green, crv_blue};
            for (int k = 3; k <= 5; k++) begin
                r_crv[k] <= r_crv[k - 1];
            end
        end
    end

    // Curves are read and written on the accept edge.
    assign crv_wr = '{we: acc && (i_command == CMD_WRITE) && (i_table_select != SEL_GRAD),
                      sel: i_table_select, idx: i_table_index, data: i_table_data};

    pcgm_curve_lut u_curve_lut (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_wr         (crv_wr),
        .i_addr_red   (i_pixel_red),
        .i_addr_green (i_pixel_green),
        .i_addr_blue  (i_pixel_blue),
        .o_red        (crv_red),
        .o_green      (crv_green),
        .o_blue       (crv_blue)
    );

    // The luma comes from the product, sum and division registers in step with stage three.
    pcgm_luma u_luma (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_red   (i_pixel_red),
        .i_green (i_pixel_green),
        .i_blue  (i_pixel_blue),
        .o_luma  (luma)
    );

    // Gradient entries are written from stage three, where pixels read them.
    assign grad_wr = '{we: en && r_vld[3] && (r_pix[3].cmd == CMD_WRITE)
                           && (r_pix[3].sel == SEL_GRAD),
                       sel: r_pix[3].sel, idx: r_pix[3].idx, data: r_pix[3].data};

    pcgm_grad_lut u_grad_lut (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_wr    (grad_wr),
        .i_addr  (luma),
        .o_entry (grad_entry)
    );

    // Stage five holds the gradient color and the alpha product.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_grad5 <= grad_entry[23:0];
            r_amul5 <= 16'(r_pix[4].alpha) * 16'(grad_entry[31:24]);
        end
    end

    // Exact floor division of a 16-bit product by 255 with two adds and shifts.
    assign div_t = 17'(r_amul5) + 17'd1;
    assign div_s = div_t + (div_t >> 8);

    always_comb begin
        n_out_red   = r_pix[5].red;
        n_out_green = r_pix[5].green;
        n_out_blue  = r_pix[5].blue;
        n_out_alpha = r_pix[5].alpha;
        if (r_pix[5].alpha != 8'd0) begin
            case (r_mode)
                MODE_CURVES: begin
                    n_out_red   = r_crv[5][23:16];
                    n_out_green = r_crv[5][15:8];
                    n_out_blue  = r_crv[5][7:0];
                end
                MODE_GRADIENT: begin
                    n_out_red   = r_grad5[23:16];
                    n_out_green = r_grad5[15:8];
                    n_out_blue  = r_grad5[7:0];
                    n_out_alpha = div_s[15:8];
                end
                default: begin
                end
            endcase
        end
    end

    // Only pixels produce a result; table writes drop out here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[5] && (r_pix[5].cmd == CMD_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_red   <= n_out_red;
            r_out_green <= n_out_green;
            r_out_blue  <= n_out_blue;
            r_out_alpha <= n_out_alpha;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;
    assign o_out_alpha = r_out_alpha;

    // The input is held off only while a finished result waits.
    `PCGM_ASSERT_NOW(a_stall_when_full, i_clk, i_rst_n, o_stall, o_valid)

    // A table write leaving the pipeline never shows up as a result.
    `PCGM_ASSERT_NEXT(a_write_no_result, i_clk, i_rst_n, en && r_vld[5] && (r_pix[5].cmd == CMD_WRITE), !o_valid)

    // A zero-alpha pixel comes out with zero alpha in every mode.
    `PCGM_ASSERT_NEXT(a_zero_alpha_pass, i_clk, i_rst_n, en && r_vld[5] && (r_pix[5].cmd == CMD_PIXEL) && (r_pix[5].alpha == 8'd0), o_valid && (o_out_alpha == 8'd0))

    // Gradient scaling never raises alpha.
    `PCGM_ASSERT_NEXT(a_grad_alpha_bound, i_clk, i_rst_n, en && r_vld[5] && (r_pix[5].cmd == CMD_PIXEL) && (r_mode == MODE_GRADIENT), o_out_alpha <= $past(r_pix[5].alpha))

endmodule

`default_nettype wire

@@ hdl/pcgm_curve_lut.sv @@
// Three 256 x 8 channel curve memories with registered reads.
`default_nettype none

module pcgm_curve_lut
    import pcgm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  t_tbl_wr    i_wr,
    input  logic [7:0] i_addr_red,
    input  logic [7:0] i_addr_green,
    input  logic [7:0] i_addr_blue,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    logic [7:0] r_mem_red   [256];
    logic [7:0] r_mem_green [256];
    logic [7:0] r_mem_blue  [256];
    logic [7:0] r_rd_red;
    logic [7:0] r_rd_green;
    logic [7:0] r_rd_blue;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            case (i_wr.sel)
                SEL_RED:   r_mem_red[i_wr.idx]   <= i_wr.data[7:0];
                SEL_GREEN: r_mem_green[i_wr.idx] <= i_wr.data[7:0];
                SEL_BLUE:  r_mem_blue[i_wr.idx]  <= i_wr.data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_red   <= r_mem_red[i_addr_red];
            r_rd_green <= r_mem_green[i_addr_green];
            r_rd_blue  <= r_mem_blue[i_addr_blue];
        end
    end

    assign o_red   = r_rd_red;
    assign o_green = r_rd_green;
    assign o_blue  = r_rd_blue;

endmodule

`default_nettype wire

@@ hdl/pcgm_luma.sv @@
// Three-stage luma unit: weighted products, sum, reciprocal division by 1000.
`default_nettype none

module pcgm_luma
    import pcgm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic [7:0] o_luma
);

    logic [16:0] r_prod_red;
    logic [17:0] r_prod_green;
    logic [14:0] r_prod_blue;
    logic [17:0] r_sum;
    logic [36:0] r_scaled;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_red   <= 17'(i_red) * 17'(LUMA_R_WEIGHT);
            r_prod_green <= 18'(i_green) * 18'(LUMA_G_WEIGHT);
            r_prod_blue  <= 15'(i_blue) * 15'(LUMA_B_WEIGHT);
            r_sum        <= 18'(r_prod_red) + r_prod_green + 18'(r_prod_blue);
            r_scaled     <= 37'(r_sum) * 37'(LUMA_RECIP);
        end
    end

    assign o_luma = r_scaled[LUMA_SHIFT +: 8];

endmodule

`default_nettype wire

@@ hdl/pcgm_grad_lut.sv @@
// 256 x 32 gradient table memory with a registered read.
`default_nettype none

module pcgm_grad_lut
    import pcgm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  t_tbl_wr     i_wr,
    input  logic [7:0]  i_addr,
    output logic [31:0] o_entry
);

    logic [31:0] r_mem [256];
    logic [31:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.we && (i_wr.sel == SEL_GRAD)) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd <= r_mem[i_addr];
        end
    end

    assign o_entry = r_rd;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the pixel curves gradient map stream.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcgm_pkg::*;

    // The spare filter mode code has no package name; the block treats it as bypass.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Luma divisor and full-scale alpha used by the mapping arithmetic.
    localparam int unsigned LUMA_DIV   = 1000;
    localparam int unsigned ALPHA_FULL = 255;

    // The drain pause lets table writes still in flight leave the pipeline.
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DIR_ROWS       = 24;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_rgba;

    // One directed row: the filter mode it runs under, the item, and where the
    // answer is obvious, the typed-in result pixel.
    typedef struct packed {
        logic [1:0]  mode;
        logic        cmd;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [1:0]  sel;
        logic [7:0]  idx;
        logic [31:0] data;
        logic        typed;
        t_rgba       res;
    } t_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_stall;
    logic        i_command      = CMD_PIXEL;
    logic [7:0]  i_pixel_red    = '0;
    logic [7:0]  i_pixel_green  = '0;
    logic [7:0]  i_pixel_blue   = '0;
    logic [7:0]  i_pixel_alpha  = '0;
    logic [1:0]  i_table_select = SEL_RED;
    logic [7:0]  i_table_index  = '0;
    logic [31:0] i_table_data   = '0;
    logic        o_valid;
    logic        i_stall        = 1'b0;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic [7:0]  o_out_alpha;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_data     = MODE_BYPASS;

    // Predictor state: the filter mode and the four lookup tables as the block holds them.
    logic [1:0]  mode_q = MODE_BYPASS;
    logic [7:0]  crv_red   [256];
    logic [7:0]  crv_green [256];
    logic [7:0]  crv_blue  [256];
    logic [31:0] grad_tbl  [256];

    // Entries already loaded, tracked on the stimulus side so that no pixel ever
    // looks up an entry that holds nothing yet.
    bit seen_red   [256];
    bit seen_green [256];
    bit seen_blue  [256];
    bit seen_grad  [256];

    // Result pixels still owed by the block, oldest first.
    t_rgba pending_px [$];

    int n_err       = 0;
    int idle_cycles = 0;
    bit burst       = 1'b0;
    bit hold_req    = 1'b0;

    // The directed rows start in bypass straight out of reset, then load the ends of
    // every table and walk through curves, gradient and the spare mode. Gradient entry
    // 76 is hit by pure red and entry 29 by pure blue; entry 76 has zero alpha.
    t_row dir_rows [DIR_ROWS] = '{
        '{MODE_BYPASS, CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'hFF, SEL_RED, 8'h00, 32'h0,
          1'b1, '{8'h00, 8'h00, 8'h00, 8'hFF}},
        '{MODE_BYPASS, CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, SEL_RED, 8'h00, 32'h0,
          1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF}},
        '{MODE_BYPASS, CMD_PIXEL, 8'hA5, 8'h5A, 8'h3C, 8'hC3, SEL_GRAD, 8'hFF, 32'hFFFFFFFF,
          1'b1, '{8'hA5, 8'h5A, 8'h3C, 8'hC3}},
        '{MODE_BYPASS, CMD_PIXEL, 8'h12, 8'h34, 8'h56, 8'h00, SEL_BLUE, 8'h80, 32'h0,
          1'b1, '{8'h12, 8'h34, 8'h56, 8'h00}},
        '{MODE_BYPASS, CMD_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, SEL_RED, 8'h00, 32'hFFFFFF12,
          1'b0, '0},
        '{MODE_BYPASS, CMD_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, SEL_RED, 8'hFF, 32'h000000ED,
          1'b0, '0},
        '{MODE_BYPASS, CMD_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, SEL_GREEN, 8'h00, 32'h12345634,
          1'b0, '0},
        '{MODE_BYPASS, CMD_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, SEL_GREEN, 8'hFF, 32'h000000CB,
          1'b0, '0},
        '{MODE_BYPASS, CMD_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, SEL_BLUE, 8'h00, 32'h00000056,
          1'b0, '0},
        '{MODE_BYPASS, CMD_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, SEL_BLUE, 8'hFF, 32'hFFFF00A9,
          1'b0, '0},
        '{MODE_BYPASS, CMD_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, SEL_GRAD, 8'h00, 32'hFF102030,
          1'b0, '0},
        '{MODE_BYPASS, CMD_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, SEL_GRAD, 8'hFF, 32'h80A0B0C0,
          1'b0, '0},
        '{MODE_BYPASS, CMD_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, SEL_GRAD, 8'd76, 32'h00FFEEDD,
          1'b0, '0},
        '{MODE_BYPASS, CMD_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, SEL_GRAD, 8'd29, 32'h7F010203,
          1'b0, '0},
        '{MODE_CURVES, CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'hFF, SEL_RED, 8'h00, 32'h0,
          1'b1, '{8'h12, 8'h34, 8'h56, 8'hFF}},
        '{MODE_CURVES, CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h01, SEL_GRAD, 8'h00, 32'h0,
          1'b1, '{8'hED, 8'hCB, 8'hA9, 8'h01}},
        '{MODE_CURVES, CMD_PIXEL, 8'hFF, 8'h00, 8'hFF, 8'h00, SEL_RED, 8'h00, 32'h0,
          1'b1, '{8'hFF, 8'h00, 8'hFF, 8'h00}},
        '{MODE_CURVES, CMD_PIXEL, 8'h00, 8'hFF, 8'h00, 8'h80, SEL_RED, 8'h00, 32'h0,
          1'b1, '{8'h12, 8'hCB, 8'h56, 8'h80}},
        '{MODE_GRADIENT, CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'hFF, SEL_RED, 8'h00, 32'h0,
          1'b1, '{8'h10, 8'h20, 8'h30, 8'hFF}},
        '{MODE_GRADIENT, CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'd200, SEL_RED, 8'h00, 32'h0,
          1'b1, '{8'hA0, 8'hB0, 8'hC0, 8'd100}},
        '{MODE_GRADIENT, CMD_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h80, SEL_RED, 8'h00, 32'h0,
          1'b1, '{8'hFF, 8'hEE, 8'hDD, 8'h00}},
        '{MODE_GRADIENT, CMD_PIXEL, 8'h00, 8'h00, 8'hFF, 8'hFF, SEL_RED, 8'h00, 32'h0,
          1'b1, '{8'h01, 8'h02, 8'h03, 8'h7F}},
        '{MODE_GRADIENT, CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h00, SEL_RED, 8'h00, 32'h0,
          1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'h00}},
        '{MODE_SPARE, CMD_PIXEL, 8'hFF, 8'h00, 8'hFF, 8'h4D, SEL_RED, 8'h00, 32'h0,
          1'b1, '{8'hFF, 8'h00, 8'hFF, 8'h4D}}
    };

    pixel_curves_gradient_map dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_pixel_red    (i_pixel_red),
        .i_pixel_green  (i_pixel_green),
        .i_pixel_blue   (i_pixel_blue),
        .i_pixel_alpha  (i_pixel_alpha),
        .i_table_select (i_table_select),
        .i_table_index  (i_table_index),
        .i_table_data   (i_table_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_out_alpha    (o_out_alpha),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // BT.601 luma, truncated; it picks the gradient entry of a pixel.
    function automatic logic [7:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        return 8'((LUMA_R_WEIGHT * r + LUMA_G_WEIGHT * g + LUMA_B_WEIGHT * b) / LUMA_DIV);
    endfunction

    // Applies one accepted item to the predictor. A table write only updates the
    // tables; a pixel yields the result pixel the block owes for it.
    function automatic void map_pixel_item(input t_pix it, output bit has_px,
                                           output t_rgba px);
        logic [31:0] ent;
        px     = '{it.red, it.green, it.blue, it.alpha};
        has_px = 1'b0;
        if (it.cmd == CMD_WRITE) begin
            case (it.sel)
                SEL_RED:   crv_red[it.idx]   = it.data[7:0];
                SEL_GREEN: crv_green[it.idx] = it.data[7:0];
                SEL_BLUE:  crv_blue[it.idx]  = it.data[7:0];
                default:   grad_tbl[it.idx]  = it.data;
            endcase
            return;
        end
        has_px = 1'b1;
        // Zero alpha passes untouched in every mode; bypass and the spare code too.
        if (it.alpha != 8'h00) begin
            if (mode_q == MODE_CURVES) begin
                px.red   = crv_red[it.red];
                px.green = crv_green[it.green];
                px.blue  = crv_blue[it.blue];
            end else if (mode_q == MODE_GRADIENT) begin
                ent      = grad_tbl[luma_of(it.red, it.green, it.blue)];
                px.red   = ent[23:16];
                px.green = ent[15:8];
                px.blue  = ent[7:0];
                px.alpha = 8'((32'(it.alpha) * 32'(ent[31:24])) / ALPHA_FULL);
            end
        end
    endfunction

    // Channel values lean toward the two extremes, so zero alpha shows up often too.
    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // A table write with random content. The pixel fields carry noise, which the
    // block has to ignore. Gradient alpha bytes of full scale and zero are favored.
    function automatic t_pix rand_write(input logic [1:0] sel, input logic [7:0] idx);
        t_pix it;
        it.cmd   = CMD_WRITE;
        it.red   = 8'($urandom_range(0, 255));
        it.green = 8'($urandom_range(0, 255));
        it.blue  = 8'($urandom_range(0, 255));
        it.alpha = 8'($urandom_range(0, 255));
        it.sel   = sel;
        it.idx   = idx;
        it.data  = $urandom;
        case ($urandom_range(0, 9))
            0, 1: it.data[31:24] = 8'hFF;
            2:    it.data[31:24] = 8'h00;
            default: ;
        endcase
        return it;
    endfunction

    // Offers one item after a random gap and waits until the block takes it. At the
    // edge of acceptance the predictor runs, so expectations line up in stream order.
    // A typed result, where the row gives one, replaces the predicted pixel.
    task automatic send_item(input t_pix it, input bit typed, input t_rgba want);
        int    gap;
        bit    has_px;
        t_rgba px;
        if (burst || $urandom_range(0, 9) < 6)
            gap = 0;
        else if ($urandom_range(0, 9) == 0)
            gap = $urandom_range(8, 25);
        else
            gap = $urandom_range(1, 3);
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        if (it.cmd == CMD_WRITE) begin
            case (it.sel)
                SEL_RED:   seen_red[it.idx]   = 1'b1;
                SEL_GREEN: seen_green[it.idx] = 1'b1;
                SEL_BLUE:  seen_blue[it.idx]  = 1'b1;
                default:   seen_grad[it.idx]  = 1'b1;
            endcase
        end
        i_valid        <= 1'b1;
        i_command      <= it.cmd;
        i_pixel_red    <= it.red;
        i_pixel_green  <= it.green;
        i_pixel_blue   <= it.blue;
        i_pixel_alpha  <= it.alpha;
        i_table_select <= it.sel;
        i_table_index  <= it.idx;
        i_table_data   <= it.data;
        do @(posedge i_clk); while (o_stall);
        map_pixel_item(it, has_px, px);
        if (has_px)
            pending_px.push_back(typed ? want : px);
    endtask

    // The filter mode may change only with the pipeline empty. Once every owed pixel
    // is out, table writes may still be in flight, so a drain pause follows.
    task automatic set_mode(input logic [1:0] m);
        i_valid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mode_q = m;
    endtask

    // One random phase under a fixed mode. Most items are pixels; before a pixel
    // would look up an entry that holds nothing yet, that entry is loaded first, so
    // no pixel maps through an empty entry. The rest are stray table writes.
    // With squeeze set, the receiver is told to hold off for a long stretch.
    task automatic run_phase(input logic [1:0] m, input int count, input bit squeeze);
        int          n;
        t_pix        it;
        logic [7:0]  l;
        bit          squeezed;
        set_mode(m);
        burst = ($urandom_range(0, 3) == 0);
        n = 0;
        squeezed = 1'b0;
        while (n < count) begin
            if (squeeze && !squeezed && n >= 15) begin
                hold_req = 1'b1;
                squeezed = 1'b1;
            end
            if (n == count / 2)
                burst = ($urandom_range(0, 2) == 0);
            it = rand_write(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) >= 3) begin
                it.cmd   = CMD_PIXEL;
                it.red   = rand_chan();
                it.green = rand_chan();
                it.blue  = rand_chan();
                it.alpha = rand_chan();
                if (m == MODE_CURVES) begin
                    if (!seen_red[it.red]) begin
                        send_item(rand_write(SEL_RED, it.red), 1'b0, '0);
                        n++;
                    end
                    if (!seen_green[it.green]) begin
                        send_item(rand_write(SEL_GREEN, it.green), 1'b0, '0);
                        n++;
                    end
                    if (!seen_blue[it.blue]) begin
                        send_item(rand_write(SEL_BLUE, it.blue), 1'b0, '0);
                        n++;
                    end
                end else if (m == MODE_GRADIENT) begin
                    l = luma_of(it.red, it.green, it.blue);
                    if (!seen_grad[l]) begin
                        send_item(rand_write(SEL_GRAD, l), 1'b0, '0);
                        n++;
                    end
                end
            end
            send_item(it, 1'b0, '0);
            n++;
        end
    endtask

    // Receiver side: free-running stretches, choppy stalls and the odd long stall,
    // plus one very long hold-off on request so the pipeline fills and backs up.
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                repeat (HOLD_CYCLES) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
                hold_req = 1'b0;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: repeat ($urandom_range(5, 40)) begin
                    i_stall <= 1'b0;
                    @(posedge i_clk);
                end
                9: repeat ($urandom_range(10, 30)) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
                default: repeat ($urandom_range(5, 30)) begin
                    i_stall <= ($urandom_range(0, 2) == 0);
                    @(posedge i_clk);
                end
            endcase
        end
    end

    // Result checker: every taken pixel must match the oldest one owed, field by field.
    always @(posedge i_clk) begin
        t_rgba want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_px.size() == 0) begin
                $error("unexpected result pixel %h %h %h %h",
                       o_out_red, o_out_green, o_out_blue, o_out_alpha);
                n_err++;
            end else begin
                want = pending_px.pop_front();
                if (o_out_red !== want.red) begin
                    $error("out_red: expected %0h, got %0h", want.red, o_out_red);
                    n_err++;
                end
                if (o_out_green !== want.green) begin
                    $error("out_green: expected %0h, got %0h", want.green, o_out_green);
                    n_err++;
                end
                if (o_out_blue !== want.blue) begin
                    $error("out_blue: expected %0h, got %0h", want.blue, o_out_blue);
                    n_err++;
                end
                if (o_out_alpha !== want.alpha) begin
                    $error("out_alpha: expected %0h, got %0h", want.alpha, o_out_alpha);
                    n_err++;
                end
            end
        end
    end

    // Watchdog: a run in which nothing moves on any channel for too long is hung.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** pixel_curves_gradient_map: FAILED **");
            $finish;
        end
    end

    // Main sequence: reset, the directed rows, then the random phases through every
    // mode, and finally a drain of all owed pixels before the verdict.
    initial begin
        t_pix it;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].mode != mode_q)
                set_mode(dir_rows[i].mode);
            it = '{dir_rows[i].cmd, dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue,
                   dir_rows[i].alpha, dir_rows[i].sel, dir_rows[i].idx, dir_rows[i].data};
            send_item(it, dir_rows[i].typed, dir_rows[i].res);
        end

        run_phase(MODE_CURVES, 60, 1'b0);
        run_phase(MODE_GRADIENT, 70, 1'b1);
        run_phase(MODE_BYPASS, 40, 1'b0);
        run_phase(MODE_GRADIENT, 70, 1'b0);
        run_phase(MODE_CURVES, 70, 1'b0);
        run_phase(MODE_SPARE, 40, 1'b0);
        run_phase(MODE_GRADIENT, 70, 1'b0);

        i_valid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_err == 0)
            $display("** pixel_curves_gradient_map: PASSED **");
        else
            $display("** pixel_curves_gradient_map: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hdl
hdl/pcgm_pkg.sv
hdl/pcgm_curve_lut.sv
hdl/pcgm_luma.sv
hdl/pcgm_grad_lut.sv
hdl/pixel_curves_gradient_map.sv
tb/tb.sv
